// File: sv/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude block.
package sgm_pkg;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int CFG_WIDTH = 13;
    localparam int ROW_WIDTH = 12;
    localparam int MAG_WIDTH = 11;

    localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_LIMIT = 13'd4096;
    localparam logic [CFG_WIDTH-1:0] FRAME_SIZE_MIN     = 13'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int ROOT_STEPS  = 11;

    // One result job handed from the front end to the square root unit.
    typedef struct packed {
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic               zero;
        logic               line_end;
        logic               frame_end;
    } t_sgm_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_LOAD
    } t_sgm_back_state;

endpackage

// File: sv/sobel_gradient_magnitude_core.sv
// Top level of the Sobel gradient magnitude block.
//
// Input channel (i_valid / o_stall): one item per handshake. A pixel item
// carries the next raster pixel; a drain item releases one pending result.
// Output channel (o_valid / i_stall): one result per handshake, with the
// magnitude and end-of-line and end-of-frame flags. Border results are zero.
// Configuration: frame width and height are written through i_cfg_we,
// i_cfg_index and i_cfg_data; a write restarts the frame. Write only while idle.
// The front end cannot take a new item until it is through with the last one:
// it reads the line store, then updates the window and queues a result job.
// An interior result then passes through the square root unit in order: it is
// taken from the queue, squared, run through 11 one-bit root steps and loaded
// into the output register; a border or drain result goes straight from the
// queue to the load. A four-entry queue between the two halves lets the front
// end keep taking items while the root unit works.
// Reset clears all positions and the window and sets 640 x 480. While i_stall
// is high the output register holds its result, the root unit finishes the
// next one and waits, and once the queue fills o_stall rises.
module sobel_gradient_magnitude_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sgm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [7:0]                    i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sgm_pkg::MAG_WIDTH-1:0] o_magnitude,
    output logic                          o_line_end,
    output logic                          o_frame_end
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          ram_re, ram_we;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [15:0]   ram_wdata, ram_rdata;
    logic          push, full, pop, empty;
    t_sgm_job      push_job, pop_job;

    // Each entry holds the two stored lines of one column: upper, then middle.
    sgm_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sgm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_pixel     (i_pixel),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    sgm_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_job)
    );

    sgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_magnitude (o_magnitude),
        .o_line_end  (o_line_end),
        .o_frame_end (o_frame_end)
    );

endmodule

// File: sv/sgm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sgm_front.sv
// Front end: accepts items, keeps the window and positions, and queues result jobs.
module sgm_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sgm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [7:0]                    i_pixel,
    output logic                          o_ram_re,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_raddr,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_ram_waddr,
    output logic [15:0]                   o_ram_wdata,
    input  logic [15:0]                   i_ram_rdata,
    output logic                          o_push,
    output sgm_pkg::t_sgm_job             o_job,
    input  logic                          i_full
);
    import sgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [CFG_WIDTH-1:0] r_frame_width, r_frame_height;
    logic                 r_busy, n_busy;
    logic                 r_cmd;
    logic [7:0]           r_pixel;
    logic [AW-1:0]        r_in_col, n_in_col;
    logic [AW-1:0]        r_out_col, n_out_col;
    logic [ROW_WIDTH-1:0] r_out_row, n_out_row;
    logic [PW-1:0]        r_pend, n_pend;
    logic [7:0]           r_win [9];
    logic [7:0]           n_win [9];

    logic [WW-1:0]        w;
    logic [CFG_WIDTH-1:0] h;
    logic [AW-1:0]        col_last, col_minus2;
    logic [ROW_WIDTH-1:0] row_last, row_minus2;
    logic [PW-1:0]        w_plus1;
    logic                 accept, emit, interior, at_line_end;
    logic [7:0]           top_px, mid_px;
    logic [10:0]          gx_pos, gx_neg, gy_pos, gy_neg;

    // Frame size clamped to the supported range.
    always_comb begin
        if (r_frame_width < FRAME_SIZE_MIN) begin
            w = WW'(FRAME_SIZE_MIN);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_frame_width);
        end
        if (r_frame_height < FRAME_SIZE_MIN) begin
            h = FRAME_SIZE_MIN;
        end else if (r_frame_height > FRAME_HEIGHT_LIMIT) begin
            h = FRAME_HEIGHT_LIMIT;
        end else begin
            h = r_frame_height;
        end
    end

    assign col_last   = AW'(w - WW'(1));
    assign col_minus2 = AW'(w - WW'(2));
    assign row_last   = ROW_WIDTH'(h - CFG_WIDTH'(1));
    assign row_minus2 = ROW_WIDTH'(h - CFG_WIDTH'(2));
    assign w_plus1    = PW'(w) + PW'(1);

    assign o_stall     = r_busy | i_full;
    assign accept      = i_valid & ~o_stall;
    assign o_ram_re    = accept;
    assign o_ram_raddr = r_in_col;
    assign top_px      = i_ram_rdata[15:8];
    assign mid_px      = i_ram_rdata[7:0];

    assign interior = (r_out_row != '0) && (r_out_row <= row_minus2)
                   && (r_out_col != '0) && (r_out_col <= col_minus2);
    assign at_line_end = (r_out_col == col_last);

    always_comb begin
        n_busy    = accept;
        n_in_col  = r_in_col;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        n_win     = r_win;
        emit      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_in_col;
        o_ram_wdata = {mid_px, r_pixel};

        if (r_busy) begin
            if (r_cmd == CMD_PIXEL) begin
                o_ram_we = 1'b1;
                for (int r = 0; r < 3; r++) begin
                    n_win[r*3]     = r_win[r*3+1];
                    n_win[r*3 + 1] = r_win[r*3+2];
                end
                n_win[2] = top_px;
                n_win[5] = mid_px;
                n_win[8] = r_pixel;
                n_in_col = (r_in_col == col_last) ? '0 : r_in_col + AW'(1);
                // The item just taken counts as pending; one leaves if more
                // than a line plus one pixel is then outstanding.
                emit   = (r_pend >= w_plus1);
                n_pend = emit ? r_pend : r_pend + PW'(1);
            end else begin
                emit   = (r_pend != '0);
                n_pend = emit ? r_pend - PW'(1) : r_pend;
            end
            if (emit) begin
                if (at_line_end) begin
                    n_out_col = '0;
                    n_out_row = (r_out_row == row_last) ? '0 : r_out_row + ROW_WIDTH'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
    end

    // Sobel sums over the updated window; both halves stay below 1024.
    assign gx_pos = {3'b0, n_win[2]} + {2'b0, n_win[5], 1'b0} + {3'b0, n_win[8]};
    assign gx_neg = {3'b0, n_win[0]} + {2'b0, n_win[3], 1'b0} + {3'b0, n_win[6]};
    assign gy_pos = {3'b0, n_win[6]} + {2'b0, n_win[7], 1'b0} + {3'b0, n_win[8]};
    assign gy_neg = {3'b0, n_win[0]} + {2'b0, n_win[1], 1'b0} + {3'b0, n_win[2]};

    assign o_push          = r_busy & emit;
    assign o_job.gx        = signed'(gx_pos - gx_neg);
    assign o_job.gy        = signed'(gy_pos - gy_neg);
    assign o_job.zero      = ~(interior & (r_cmd == CMD_PIXEL));
    assign o_job.line_end  = at_line_end;
    assign o_job.frame_end = at_line_end & (r_out_row == row_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_busy         <= 1'b0;
            r_in_col       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_pend         <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_busy <= n_busy;
            r_win  <= n_win;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    r_frame_width <= i_cfg_data;
                end else begin
                    r_frame_height <= i_cfg_data;
                end
                // A register write starts a new frame.
                r_in_col  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_pend    <= '0;
            end else begin
                r_in_col  <= n_in_col;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_pend    <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_pixel <= i_pixel;
        end
    end

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("front end stayed busy for more than one cycle");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= w_plus1)
        else $error("pending result count exceeds one line plus one pixel");

endmodule

// File: sv/sgm_fifo.sv
// Short job queue between the front end and the square root unit.
module sgm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sgm_pkg::t_sgm_job i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output sgm_pkg::t_sgm_job o_data
);
    import sgm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_sgm_job           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/sgm_back.sv
// Back end: squares the gradients, takes the integer square root, holds the result.
module sgm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  sgm_pkg::t_sgm_job             i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sgm_pkg::MAG_WIDTH-1:0] o_magnitude,
    output logic                          o_line_end,
    output logic                          o_frame_end
);
    import sgm_pkg::*;

    localparam int RAD_W = 2 * ROOT_STEPS;
    localparam int REM_W = MAG_WIDTH + 2;
    localparam int CNT_W = $clog2(ROOT_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_STEPS - 1);

    t_sgm_back_state       r_state, n_state;
    t_sgm_job              r_job, n_job;
    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [MAG_WIDTH-1:0]  r_root, n_root;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [MAG_WIDTH-1:0]  r_mag;
    logic                  r_line_end, r_frame_end;

    logic                  out_free, load;
    logic signed [RAD_W-1:0] gx_ext, gy_ext;
    logic [RAD_W-1:0]      energy;
    logic [REM_W+1:0]      rem_sh, trial;

    assign gx_ext = RAD_W'(r_job.gx);
    assign gy_ext = RAD_W'(r_job.gy);
    assign energy = RAD_W'(gx_ext * gx_ext) + RAD_W'(gy_ext * gy_ext);

    // One result bit per step: bring down the next two radicand bits and
    // try to subtract 4*root + 1.
    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({r_root, 2'b01});

    assign out_free = ~r_out_valid | ~i_stall;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_count = r_count;
        o_pop   = 1'b0;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_root  = '0;
                    n_state = i_job.zero ? ST_LOAD : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_rad   = energy;
                n_rem   = '0;
                n_root  = '0;
                n_count = '0;
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (rem_sh >= trial) begin
                    n_rem  = REM_W'(rem_sh - trial);
                    n_root = {r_root[MAG_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(rem_sh);
                    n_root = {r_root[MAG_WIDTH-2:0], 1'b0};
                end
                n_rad   = {r_rad[RAD_W-3:0], 2'b00};
                n_count = r_count + CNT_W'(1);
                if (r_count == LAST_STEP) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = load | (r_out_valid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        if (load) begin
            r_mag       <= r_root;
            r_line_end  <= r_job.line_end;
            r_frame_end <= r_job.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_mag;
    assign o_line_end  = r_line_end;
    assign o_frame_end = r_frame_end;

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROOT |-> r_count <= LAST_STEP)
        else $error("square root step counter ran past the last step");

    a_square_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SQUARE |=> r_state == ST_ROOT && r_count == '0)
        else $error("square root did not start at its first step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD && r_out_valid && i_stall |=> r_state == ST_LOAD)
        else $error("finished result left the unit while output was stalled");

endmodule

// File: verif/sobel_gradient_magnitude_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts each Sobel magnitude result and compares the block output against it.
module sobel_gradient_magnitude_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sgm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_command,
    input  logic [7:0]                    i_pixel,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [sgm_pkg::MAG_WIDTH-1:0] i_magnitude,
    input  logic                          i_line_end,
    input  logic                          i_frame_end,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_nonzero_count
);
    import sgm_pkg::*;

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [MAG_WIDTH-1:0] magnitude;
        logic                 line_end;
        logic                 frame_end;
    } sobel_result_t;

    logic [CFG_WIDTH-1:0] width_reg;
    logic [CFG_WIDTH-1:0] height_reg;
    logic [7:0]           upper_line [MAX_WIDTH];
    logic [7:0]           middle_line [MAX_WIDTH];
    logic [7:0]           window_px [9];
    int unsigned          in_col;
    int unsigned          in_row;
    int unsigned          out_col;
    int unsigned          out_row;
    sobel_result_t        expected_q [$];
    int                   fails;
    int                   results;
    int                   nonzero;

    function automatic int unsigned clamp_size(input logic [CFG_WIDTH-1:0] raw,
                                               input int unsigned upper);
        int unsigned v;
        v = raw;
        if (v < 3) v = 3;
        if (v > upper) v = upper;
        return v;
    endfunction

    // Builds the root one bit at a time from the top, keeping each bit whose square fits.
    function automatic int unsigned floor_root(input int unsigned energy);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = MAG_WIDTH - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= energy) root = trial;
        end
        return root;
    endfunction

    function automatic int tap(input int k);
        return int'(window_px[k]);
    endfunction

    function automatic int unsigned window_magnitude();
        int gx;
        int gy;
        gx = (tap(2) + 2 * tap(5) + tap(8)) - (tap(0) + 2 * tap(3) + tap(6));
        gy = (tap(6) + 2 * tap(7) + tap(8)) - (tap(0) + 2 * tap(1) + tap(2));
        return floor_root(gx * gx + gy * gy);
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void note_mismatch(input string field,
                                          input logic [MAG_WIDTH-1:0] want,
                                          input logic [MAG_WIDTH-1:0] got);
        fails++;
        if (fails <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    task automatic predict_item(input logic cmd, input logic [7:0] px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   total;
        int unsigned   gap;
        logic [7:0]    top_px;
        logic [7:0]    mid_px;
        logic          interior;
        sobel_result_t res;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, FRAME_HEIGHT_LIMIT);
        total = w * h;
        if (cmd == CMD_PIXEL) begin
            top_px = upper_line[in_col];
            mid_px = middle_line[in_col];
            upper_line[in_col] = mid_px;
            middle_line[in_col] = px;
            for (int r = 0; r < 3; r++) begin
                window_px[r * 3]     = window_px[r * 3 + 1];
                window_px[r * 3 + 1] = window_px[r * 3 + 2];
            end
            window_px[2] = top_px;
            window_px[5] = mid_px;
            window_px[8] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
        end
        gap = (in_row * w + in_col + total - (out_row * w + out_col)) % total;
        // A pixel releases a result only once more than a line plus one pixel is pending.
        if ((cmd == CMD_DRAIN) ? (gap == 0) : (gap <= w + 1)) return;
        interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
        res.magnitude = (interior && cmd == CMD_PIXEL) ? MAG_WIDTH'(window_magnitude()) : '0;
        res.line_end  = (out_col == w - 1);
        res.frame_end = (out_col == w - 1) && (out_row == h - 1);
        expected_q.push_back(res);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
    endtask

    always @(posedge i_clk) begin : track
        sobel_result_t want;
        sobel_result_t got;
        if (!i_rst_n) begin
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (upper_line[k]) upper_line[k] = '0;
            foreach (middle_line[k]) middle_line[k] = '0;
            foreach (window_px[k]) window_px[k] = '0;
            restart_frame();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  width_reg = i_cfg_data;
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
                restart_frame();
            end
            if (i_in_valid && !i_in_stall) predict_item(i_command, i_pixel);
            if (i_out_valid && !i_out_stall) begin
                got.magnitude = i_magnitude;
                got.line_end  = i_line_end;
                got.frame_end = i_frame_end;
                results++;
                if (got.magnitude != '0) nonzero++;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, got magnitude %0d",
                                 $time, got.magnitude);
                end else begin
                    want = expected_q.pop_front();
                    if (got.magnitude !== want.magnitude)
                        note_mismatch("magnitude", want.magnitude, got.magnitude);
                    if (got.line_end !== want.line_end)
                        note_mismatch("line_end", want.line_end, got.line_end);
                    if (got.frame_end !== want.frame_end)
                        note_mismatch("frame_end", want.frame_end, got.frame_end);
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_q.size();
        o_result_count  <= results;
        o_nonzero_count <= nonzero;
    end

endmodule

// File: verif/sobel_gradient_magnitude_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Sobel gradient magnitude core: stimulus, flow control and verdict.
module sobel_gradient_magnitude_core_tb;
    import sgm_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_PIXELS = 1400;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {
        PAT_RANDOM,
        PAT_BINARY,
        PAT_DIAGONAL,
        PAT_STEP,
        PAT_LOW
    } pattern_t;

    typedef enum int {
        PLAN_FRAMES,
        PLAN_WIDE,
        PLAN_TALL
    } plan_t;

    localparam logic [7:0] CORNER_FRAME [9] = '{
        8'h00, 8'h00, 8'hFF,
        8'h00, 8'h5A, 8'hFF,
        8'h00, 8'hFF, 8'hFF
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = REG_FRAME_WIDTH;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 in_command = CMD_PIXEL;
    logic [7:0]           in_pixel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MAG_WIDTH-1:0] out_magnitude;
    logic                 out_line_end;
    logic                 out_frame_end;

    int fail_count;
    int pending_results;
    int result_count;
    int nonzero_count;

    int          cycle_count = 0;
    int          hold_asked = 0;
    bit          quiet = 1'b0;
    int unsigned cur_w = 640;
    int unsigned cur_h = 480;
    int          pixels_sent = 0;
    int          drains_sent = 0;
    int          size_settings = 0;

    sobel_gradient_magnitude_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_command   (in_command),
        .i_pixel     (in_pixel),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_magnitude (out_magnitude),
        .o_line_end  (out_line_end),
        .o_frame_end (out_frame_end)
    );

    sobel_gradient_magnitude_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (in_command),
        .i_pixel         (in_pixel),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_magnitude     (out_magnitude),
        .i_line_end      (out_line_end),
        .i_frame_end     (out_frame_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results),
        .o_result_count  (result_count),
        .o_nonzero_count (nonzero_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles, %0d results still outstanding",
                     cycle_count, pending_results);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request so the block backs up.
    initial begin : result_side
        int hold_left = 0;
        int hold_served = 0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 12);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] px);
        while (!quiet && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_pixel   <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == CMD_PIXEL) pixels_sent++;
        else drains_sent++;
    endtask

    // Settles the block before a register write: every result in, then a short pause.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [CFG_WIDTH-1:0] raw_w,
                                  input logic [CFG_WIDTH-1:0] raw_h,
                                  input int unsigned eff_w, input int unsigned eff_h);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= raw_w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= raw_h;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = eff_w;
        cur_h = eff_h;
        size_settings++;
    endtask

    function automatic logic [7:0] pixel_at(input pattern_t pat, input int unsigned idx);
        int unsigned r;
        int unsigned c;
        r = (idx / cur_w) % cur_h;
        c = idx % cur_w;
        case (pat)
            PAT_BINARY:   return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            PAT_DIAGONAL: return (c >= r) ? 8'hFF : 8'h00;
            PAT_STEP:     return (c >= cur_w / 2) ? 8'hFF : 8'h00;
            PAT_LOW:      return 8'($urandom_range(15));
            default:      return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixels(input pattern_t pat, input int unsigned first,
                               input int unsigned count, input int noise_pct);
        for (int unsigned n = 0; n < count; n++) begin
            if (noise_pct > 0 && $urandom_range(99) < noise_pct)
                send_item(CMD_DRAIN, 8'($urandom_range(255)));
            send_item(CMD_PIXEL, pixel_at(pat, first + n));
        end
    endtask

    task automatic send_drains(input int unsigned count);
        repeat (count) send_item(CMD_DRAIN, 8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        int          phase;
        int          pick;
        int          noise;
        int          ending;
        int          directed_pixels;
        int unsigned area;
        int unsigned split;
        int unsigned count;
        plan_t       plan;
        pattern_t    pat;
        logic [CFG_WIDTH-1:0] raw_w;
        logic [CFG_WIDTH-1:0] raw_h;
        int unsigned eff_w;
        int unsigned eff_h;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: a couple of extreme pixels, then drains including one with nothing left.
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hFF);
        send_drains(3);

        // Undersized registers clamp to 3x3; the corner pattern gives a strong interior edge.
        set_frame_size(13'd0, 13'd2, 3, 3);
        for (int k = 0; k < 9; k++) send_item(CMD_PIXEL, CORNER_FRAME[k]);
        // The next frame pushes out the trailing border results of the previous one.
        for (int k = 0; k < 5; k++) send_item(CMD_PIXEL, 8'($urandom_range(255)));
        // Drains reach the centre before its neighbours exist, so it comes out as zero.
        send_drains(5);
        directed_pixels = pixels_sent;

        phase = 0;
        while (pixels_sent < directed_pixels + RANDOM_PIXELS) begin
            phase++;
            pick  = $urandom_range(99);
            noise = ($urandom_range(9) < 3) ? 4 : 0;
            pat   = pattern_t'($urandom_range(PAT_LOW));
            plan  = PLAN_FRAMES;
            if (phase <= 2) begin
                raw_w = (phase == 1) ? 13'd10 : 13'd16;
                raw_h = (phase == 1) ? 13'd8 : 13'd6;
                eff_w = raw_w;
                eff_h = raw_h;
                noise = 0;
            end else if (pick < 8) begin
                plan  = PLAN_WIDE;
                raw_w = 13'($urandom_range(4096, 8191));
                raw_h = 13'($urandom_range(3, 9));
                eff_w = 4096;
                eff_h = raw_h;
            end else if (pick < 14) begin
                plan  = PLAN_TALL;
                raw_w = 13'($urandom_range(3, 8));
                raw_h = ($urandom_range(1) != 0) ? 13'd4096 : 13'($urandom_range(4097, 8191));
                eff_w = raw_w;
                eff_h = 4096;
            end else if (pick < 26) begin
                raw_w = 13'($urandom_range(0, 3));
                raw_h = 13'($urandom_range(0, 3));
                eff_w = 3;
                eff_h = 3;
            end else begin
                raw_w = 13'($urandom_range(3, 14));
                raw_h = 13'($urandom_range(3, 9));
                eff_w = raw_w;
                eff_h = raw_h;
            end
            set_frame_size(raw_w, raw_h, eff_w, eff_h);
            if (phase == 1) hold_asked++;
            quiet = (phase == 2);
            area = cur_w * cur_h;

            case (plan)
                PLAN_WIDE: begin
                    count = $urandom_range(20, 60);
                    send_pixels(pat, 0, count, noise);
                    send_drains(count + 1);
                end
                PLAN_TALL: begin
                    send_pixels(pat, 0, $urandom_range(2, 4) * cur_w, noise);
                    send_drains(cur_w + 2);
                end
                default: begin
                    send_pixels(pat, 0, $urandom_range(1, 3) * area, noise);
                    ending = (phase <= 2) ? 0 : $urandom_range(2);
                    if (ending == 0) begin
                        send_drains(cur_w + 2);
                    end else if (ending == 1) begin
                        // Drain part way into a frame, then finish it.
                        split = $urandom_range(1, area - 1);
                        send_pixels(pat, 0, split, noise);
                        send_drains($urandom_range(1, cur_w + 2));
                        send_pixels(pat, split, area - split, noise);
                        send_drains(cur_w + 2);
                    end else begin
                        // Leave results pending; the next register write drops them.
                        send_pixels(pat, 0, $urandom_range(1, area - 1), noise);
                    end
                end
            endcase
            quiet = 1'b0;
        end

        wait_idle();
        $display("Sent %0d pixel items and %0d drain items across %0d frame size settings.",
                 pixels_sent, drains_sent, size_settings);
        $display("Checked %0d results (%0d nonzero), from clamped 3x3 up to 4096-wide and tall.",
                 result_count, nonzero_count);
        if (fail_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
